// ===== rtl/core/lpmd_pkg.sv =====
// Shared constants and types for the length-prefixed message deframer.
// No dependencies; imported by every module of the block and by its checker.
package lpmd_pkg;

   // Configuration port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [0:0]  REG_MAX_LENGTH = 1'b0;
   localparam logic [31:0] MAX_LENGTH_RESET = 32'd65536;

   // Framing
   localparam int unsigned LENGTH_BYTES = 4;
   localparam int unsigned ID_BYTES = 2;
   localparam logic [31:0] MIN_LENGTH = 32'(ID_BYTES);

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Word held in the input register
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } in_word_type;

   // Handshake between parser and input register
   typedef struct packed {
      logic take;
   } in_ctrl_type;

endpackage

// ===== rtl/core/lpmd_csr.sv =====
// Configuration register file: holds max_length behind an APB-style port.
// Depends on lpmd_pkg.
module lpmd_csr
   import lpmd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [31:0]           max_length
);

   logic [31:0] max_length_ff;
   logic [31:0] max_length_in;
   logic        sel_max;

   assign sel_max = (paddr[2] == REG_MAX_LENGTH);

   always_comb begin
      max_length_in = max_length_ff;
      if (psel && penable && pwrite && sel_max) begin
         max_length_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
      end else begin
         max_length_ff <= max_length_in;
      end
   end

   assign prdata     = sel_max ? max_length_ff : '0;
   assign pready     = 1'b1;
   assign max_length = max_length_ff;

endmodule

// ===== rtl/core/lpmd_in_reg.sv =====
// Input register: captures one stream byte a cycle while the parser keeps taking them, and hands it to the parser.
// Depends on lpmd_pkg.
module lpmd_in_reg
   import lpmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  in_ctrl_type ctrl,
   output in_word_type word
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;
   logic [7:0] data_in;

   // free when empty or when the parser takes the held word this cycle
   assign req_ready = !valid_ff || ctrl.take;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         data_in  = req_in_byte;
      end else if (ctrl.take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign word.valid = valid_ff;
   assign word.data  = data_ff;

endmodule

// ===== rtl/core/lpmd_parser.sv =====
// Framing parser: header assembly, length check, payload count, result register.
// Depends on lpmd_pkg; fed by lpmd_in_reg.
module lpmd_parser
   import lpmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] max_length,
   input  in_word_type word,
   output in_ctrl_type ctrl,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data,
   output logic [15:0] rsp_message_tag,
   output logic        rsp_last
);

   typedef enum logic [1:0] {
      PH_LENGTH  = 2'd0,
      PH_ID      = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  hcount_ff, hcount_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [15:0] tag_ff, tag_in;
   logic        failed_ff, failed_in;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  data_ff, data_in;
   logic [15:0] otag_ff, otag_in;
   logic        last_ff, last_in;

   logic        take;
   logic        res_valid;
   logic [1:0]  hcount_inc;
   logic [31:0] length_new;
   logic [15:0] tag_new;
   logic [31:0] remaining_dec;

   // process a word when the result register is free or being emptied
   assign take      = word.valid && (!out_valid_ff || rsp_ready);
   assign ctrl.take = take;

   assign hcount_inc    = hcount_ff + 2'd1;
   assign length_new    = length_ff | ({24'd0, word.data} << {hcount_ff, 3'b000});
   assign tag_new       = tag_ff | ({8'd0, word.data} << {hcount_ff[0], 3'b000});
   assign remaining_dec = (remaining_ff == '0) ? '0 : remaining_ff - 32'd1;

   always_comb begin
      phase_in     = phase_ff;
      hcount_in    = hcount_ff;
      length_in    = length_ff;
      remaining_in = remaining_ff;
      tag_in       = tag_ff;
      failed_in    = failed_ff;
      res_valid    = 1'b0;
      kind_in      = KIND_PAYLOAD;
      data_in      = '0;
      otag_in      = '0;
      last_in      = 1'b0;

      if (!failed_ff) begin
         case (phase_ff)
            PH_ID: begin
               tag_in    = tag_new;
               hcount_in = hcount_inc;
               if (hcount_inc >= 2'(ID_BYTES)) begin
                  hcount_in = '0;
                  if (remaining_ff == '0) begin
                     phase_in  = PH_LENGTH;
                     res_valid = 1'b1;
                     kind_in   = KIND_EMPTY;
                     otag_in   = tag_new;
                     last_in   = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               remaining_in = remaining_dec;
               if (remaining_dec == '0) begin
                  phase_in = PH_LENGTH;
               end
               res_valid = 1'b1;
               kind_in   = KIND_PAYLOAD;
               data_in   = word.data;
               otag_in   = tag_ff;
               last_in   = (remaining_ff <= 32'd1);
            end
            default: begin
               // length phase, also the spare phase code
               phase_in  = PH_LENGTH;
               length_in = length_new;
               hcount_in = hcount_inc;
               if (hcount_ff == 2'(LENGTH_BYTES - 1)) begin
                  hcount_in = '0;
                  length_in = '0;
                  if (length_new > max_length || length_new < MIN_LENGTH) begin
                     failed_in = 1'b1;
                     res_valid = 1'b1;
                     kind_in   = KIND_ERROR;
                     last_in   = 1'b1;
                  end else begin
                     remaining_in = length_new - MIN_LENGTH;
                     tag_in       = '0;
                     phase_in     = PH_ID;
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = res_valid;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LENGTH;
         hcount_ff    <= '0;
         length_ff    <= '0;
         remaining_ff <= '0;
         tag_ff       <= '0;
         failed_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff     <= phase_in;
            hcount_ff    <= hcount_in;
            length_ff    <= length_in;
            remaining_ff <= remaining_in;
            tag_ff       <= tag_in;
            failed_ff    <= failed_in;
         end
         out_valid_ff <= out_valid_in;
      end
      if (take && res_valid) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
         otag_ff <= otag_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_data        = data_ff;
   assign rsp_message_tag = otag_ff;
   assign rsp_last        = last_ff;

endmodule

// ===== rtl/core/length_prefixed_message_deframer.sv =====
// Top level of the length-prefixed message deframer.
// Depends on lpmd_pkg, lpmd_csr, lpmd_in_reg and lpmd_parser.
//
//   channel | handshake             | payload
//   --------+-----------------------+--------------------------------------------
//   req     | req_valid/req_ready   | req_in_byte
//   rsp     | rsp_valid/rsp_ready   | rsp_kind, rsp_data, rsp_message_tag, rsp_last
//   csr     | psel/penable, pready  | pwrite, paddr, pwdata, prdata
//
// One byte a cycle sustained while rsp_ready stays high; a byte passes through the input
// register, then the parser into the result register, before its result word shows on rsp.
// Reset is synchronous: it clears the header state and the failed flag and sets
// max_length back to 65536.
// A stalled result holds the result register and the parser; req_ready then stays
// high only while the input register is empty, so at most two words are held.
module length_prefixed_message_deframer
   import lpmd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_in_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_data,
   output logic [15:0]           rsp_message_tag,
   output logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [31:0] max_length;
   in_word_type word;
   in_ctrl_type ctrl;

   lpmd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .max_length (max_length)
   );

   lpmd_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .ctrl        (ctrl),
      .word        (word)
   );

   lpmd_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .max_length      (max_length),
      .word            (word),
      .ctrl            (ctrl),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_data        (rsp_data),
      .rsp_message_tag (rsp_message_tag),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== rtl/core/lpmd_checker.sv =====
// Port-level checker for the deframer, attached to the top level by bind.
// Depends on lpmd_pkg and length_prefixed_message_deframer.
module lpmd_checker
   import lpmd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_data,
   input logic [15:0] rsp_message_tag,
   input logic        rsp_last,
   input logic        pready
);

   // hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_data)
         && $stable(rsp_message_tag) && $stable(rsp_last))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERROR |->
         rsp_last && rsp_data == '0 && rsp_message_tag == '0)
      else $error("malformed error result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_EMPTY |-> rsp_last && rsp_data == '0)
      else $error("malformed empty-message result");

   // after an error the block stays silent until reset
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_kind == KIND_ERROR |=> !rsp_valid)
      else $error("result after bad length");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_PAYLOAD || rsp_kind == KIND_EMPTY
         || rsp_kind == KIND_ERROR) && pready)
      else $error("bad result kind or pready low");

endmodule

bind length_prefixed_message_deframer lpmd_checker u_lpmd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_kind        (rsp_kind),
   .rsp_data        (rsp_data),
   .rsp_message_tag (rsp_message_tag),
   .rsp_last        (rsp_last),
   .pready          (pready)
);

// ===== sim/lpmd_frame_checker.sv =====
// Result checker for the length-prefixed message deframer: watches the byte, result
// and register ports, predicts every result word and compares it field by field.
// Depends on lpmd_pkg.
module lpmd_frame_checker
   import lpmd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [7:0]            req_in_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [1:0]            rsp_kind,
   input  logic [7:0]            rsp_data,
   input  logic [15:0]           rsp_message_tag,
   input  logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic [CSR_DATA_W-1:0] prdata,
   input  logic                  pready,
   output int                    mismatch_count,
   output int                    results_due
);

   typedef enum logic [1:0] {
      SEEK_LENGTH = 2'd0,
      SEEK_TAG    = 2'd1,
      IN_PAYLOAD  = 2'd2
   } frame_phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [15:0] tag;
      logic        last;
   } frame_result_type;

   frame_result_type due_results[$];
   frame_phase_type  phase;
   int unsigned      header_bytes;
   logic [31:0]      length_acc;
   logic [31:0]      payload_left;
   logic [15:0]      tag_acc;
   logic             halted;
   logic [31:0]      max_length;

   task automatic clear_state();
      phase = SEEK_LENGTH;
      header_bytes = 0;
      length_acc = '0;
      payload_left = '0;
      tag_acc = '0;
      halted = 1'b0;
      max_length = MAX_LENGTH_RESET;
      due_results.delete();
   endtask

   // Advance the framing state by one received byte and queue any result it owes.
   task automatic parse_stream_byte(input logic [7:0] b);
      frame_result_type r;
      if (!halted) begin
         case (phase)
            SEEK_TAG: begin
               tag_acc = tag_acc | (16'(b) << (8 * header_bytes));
               header_bytes++;
               if (header_bytes == ID_BYTES) begin
                  header_bytes = 0;
                  if (payload_left == 0) begin
                     phase = SEEK_LENGTH;
                     r = '{kind: KIND_EMPTY, data: 8'd0, tag: tag_acc, last: 1'b1};
                     due_results.insert(due_results.size(), r);
                  end else begin
                     phase = IN_PAYLOAD;
                  end
               end
            end
            IN_PAYLOAD: begin
               r = '{kind: KIND_PAYLOAD, data: b, tag: tag_acc, last: payload_left <= 1};
               if (payload_left != 0) payload_left = payload_left - 1;
               if (payload_left == 0) phase = SEEK_LENGTH;
               due_results.insert(due_results.size(), r);
            end
            default: begin
               phase = SEEK_LENGTH;
               length_acc = length_acc | (32'(b) << (8 * header_bytes));
               header_bytes++;
               if (header_bytes == LENGTH_BYTES) begin
                  header_bytes = 0;
                  if (length_acc > max_length || length_acc < MIN_LENGTH) begin
                     // a bad length locks the block up until reset
                     halted = 1'b1;
                     r = '{kind: KIND_ERROR, data: 8'd0, tag: 16'd0, last: 1'b1};
                     due_results.insert(due_results.size(), r);
                  end else begin
                     payload_left = length_acc - MIN_LENGTH;
                     tag_acc = '0;
                     phase = SEEK_TAG;
                  end
                  length_acc = '0;
               end
            end
         endcase
      end
   endtask

   task automatic check_result();
      frame_result_type want;
      if (due_results.size() == 0) begin
         $error("result word with none due: kind %0d data %0h tag %0h last %0b",
                rsp_kind, rsp_data, rsp_message_tag, rsp_last);
         mismatch_count++;
      end else begin
         want = due_results[0];
         due_results.delete(0);
         if (rsp_kind !== want.kind) begin
            $error("rsp_kind: expected %0d, got %0d", want.kind, rsp_kind);
            mismatch_count++;
         end
         if (rsp_data !== want.data) begin
            $error("rsp_data: expected %0h, got %0h", want.data, rsp_data);
            mismatch_count++;
         end
         if (rsp_message_tag !== want.tag) begin
            $error("rsp_message_tag: expected %0h, got %0h", want.tag, rsp_message_tag);
            mismatch_count++;
         end
         if (rsp_last !== want.last) begin
            $error("rsp_last: expected %0b, got %0b", want.last, rsp_last);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (req_valid && req_ready) parse_stream_byte(req_in_byte);
         if (psel && penable && pready && paddr[CSR_ADDR_W-1:2] == REG_MAX_LENGTH) begin
            if (pwrite) begin
               max_length = pwdata;
            end else if (prdata !== max_length) begin
               $error("prdata: expected %0h, got %0h", max_length, prdata);
               mismatch_count++;
            end
         end
      end
      results_due = due_results.size();
   end

endmodule

// ===== sim/tb_length_prefixed_message_deframer.sv =====
// Testbench top for the length-prefixed message deframer: drives framed byte
// streams, register writes and back-pressure, and gives the verdict.
// Depends on lpmd_pkg, length_prefixed_message_deframer and lpmd_frame_checker.
module tb_length_prefixed_message_deframer;
   import lpmd_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 10;
   localparam int DRAIN_CYCLES = 6;
   localparam int STALL_CYCLES = 80;
   localparam int PHASE_WORDS  = 240;
   localparam longint LIMIT_CYCLES = 400_000;
   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_LENGTH = CSR_ADDR_W'({REG_MAX_LENGTH, 2'b00});
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED = ADDR_MAX_LENGTH + CSR_ADDR_W'(4);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_in_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_kind;
   logic [7:0]            rsp_data;
   logic [15:0]           rsp_message_tag;
   logic                  rsp_last;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    mismatch_count;
   int                    results_due;

   logic        sender_idles = 1'b1;
   logic        receiver_idles = 1'b1;
   logic        hold_request = 1'b0;
   logic [31:0] max_setting = MAX_LENGTH_RESET;
   int          words_sent = 0;

   length_prefixed_message_deframer dut (.*);
   lpmd_frame_checker frame_monitor (.*);

   always #(HALF_PERIOD) clock = ~clock;

   initial begin : run_limit
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : result_sink
      int burst;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            // hold off long enough for the input side to back up
            rsp_ready <= 1'b0;
            repeat (STALL_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 10);
            rsp_ready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Called and returns at a falling edge.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_header(input logic [31:0] length, input logic [15:0] id);
      for (int i = 0; i < LENGTH_BYTES; i++) send_byte(length[8*i +: 8]);
      send_byte(id[7:0]);
      send_byte(id[15:8]);
   endtask

   task automatic send_message(input logic [31:0] length, input logic [15:0] id);
      send_header(length, id);
      repeat (length - MIN_LENGTH) send_byte(8'($urandom));
   endtask

   // Drop valid and wait for every owed result plus the header bytes in flight.
   task automatic settle();
      req_valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic is_write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [31:0] wdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= addr;
      pwdata <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_max_length(input logic [31:0] value);
      settle();
      csr_access(1'b1, ADDR_MAX_LENGTH, value);
      csr_access(1'b0, ADDR_MAX_LENGTH, '0);
      max_setting = value;
   endtask

   // Mostly short messages, with empty ones and ones at the limit or at 40, whichever is lower.
   function automatic logic [31:0] pick_length();
      logic [31:0] cap;
      cap = (max_setting < 32'd40) ? max_setting : 32'd40;
      case ($urandom_range(0, 7))
         0: return MIN_LENGTH;
         1: return cap;
         default: return MIN_LENGTH + $urandom_range(0, cap - MIN_LENGTH);
      endcase
   endfunction

   initial begin : stimulus
      logic [31:0] bad_length;
      int phase_end;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_access(1'b0, ADDR_MAX_LENGTH, '0);

      // empty message, then a single-byte one, tags at both extremes
      send_header(32'd2, 16'hFFFF);
      send_header(32'd3, 16'h0000);
      send_byte(8'hFF);
      // change the limit half way through a length; it still governs that length
      send_byte(8'd4);
      send_byte(8'd0);
      set_max_length(32'd4);
      send_byte(8'd0);
      send_byte(8'd0);
      send_byte(8'h5A);
      send_byte(8'hA5);
      send_byte(8'h00);
      send_byte(8'h80);
      // writes beyond the one register are ignored
      settle();
      csr_access(1'b1, ADDR_UNMAPPED, 32'd3);
      csr_access(1'b0, ADDR_MAX_LENGTH, '0);

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: set_max_length(MIN_LENGTH);
            1: set_max_length(32'hFFFF_FFFF);
            2: set_max_length(32'($urandom_range(3, 40)));
            3: set_max_length(MAX_LENGTH_RESET);
            4: set_max_length(32'($urandom_range(2, 300)));
            default: set_max_length(32'($urandom_range(2, 60)));
         endcase
         if (p == 1) begin
            hold_request = 1'b1;
            send_message(32'd42, 16'($urandom));
         end
         if (p == 5) begin
            sender_idles = 1'b0;
            receiver_idles = 1'b0;
         end
         phase_end = words_sent + PHASE_WORDS;
         while (words_sent < phase_end) send_message(pick_length(), 16'($urandom));
      end

      // one bad length, after which everything is dropped
      case ($urandom_range(0, 3))
         0: bad_length = 32'd0;
         1: bad_length = MIN_LENGTH - 1;
         2: bad_length = max_setting + 1;
         default: bad_length = 32'hFFFF_FFFF;
      endcase
      send_header(bad_length, 16'($urandom));
      repeat (20) send_byte(8'($urandom));
      settle();

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
